// ===== rtl/lmts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmts_pkg
// Shared types, codes and the proportional font for the LED matrix scroller.
// ----------------------------------------------------------------------------
package lmts_pkg;

    // Request kinds carried on the input stream's tuser
    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_RESTART = 2'd1,
        OP_TICK    = 2'd2
    } op_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPACE_GAP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRAP_GAP  = 2'd1;

    // Field widths
    localparam int OP_W        = 2;
    localparam int INDEX_W     = 6;
    localparam int CODE_W      = 8;
    localparam int GAP_W       = 4;
    localparam int COUNT_W     = 4;
    localparam int ROW_W       = 8;
    localparam int MATRIX_ROWS = 8;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = MATRIX_ROWS * ROW_W;

    // Gap register reset values
    localparam logic [GAP_W-1:0] SPACE_GAP_RESET = 4'd3;
    localparam logic [GAP_W-1:0] WRAP_GAP_RESET  = 4'd8;

    // Character codes
    localparam logic [CODE_W-1:0] CODE_NUL     = 8'h00;
    localparam logic [CODE_W-1:0] CODE_SPACE   = 8'h20;
    localparam logic [CODE_W-1:0] CODE_DIGIT_0 = 8'h30;
    localparam logic [CODE_W-1:0] CODE_DIGIT_9 = 8'h39;
    localparam logic [CODE_W-1:0] CODE_UPPER_A = 8'h41;
    localparam logic [CODE_W-1:0] CODE_UPPER_Z = 8'h5A;
    localparam logic [CODE_W-1:0] CODE_LOWER_A = 8'h61;
    localparam logic [CODE_W-1:0] CODE_LOWER_Z = 8'h7A;

    // Font layout
    localparam int LETTER_COUNT  = 26;
    localparam int LOWER_BASE    = LETTER_COUNT;
    localparam int DIGIT_BASE    = LETTER_COUNT * 2;
    localparam int GLYPH_COUNT   = 62;
    localparam int GLYPH_IDX_W   = 6;
    localparam int GLYPH_ROW_W   = 5;
    localparam int GLYPH_WIDTH_W = 3;
    localparam int GLYPH_ENTRY_W = MATRIX_ROWS * GLYPH_ROW_W + GLYPH_WIDTH_W;
    localparam logic [GLYPH_WIDTH_W-1:0] BLANK_WIDTH = 3'd3;

    typedef logic [MATRIX_ROWS-1:0][ROW_W-1:0] frame_t;

    typedef struct packed {
        logic [GLYPH_WIDTH_W-1:0]                  width;
        logic [MATRIX_ROWS-1:0][GLYPH_ROW_W-1:0]   rows;
    } glyph_t;

    // Pending lookahead loads from the text store read ports
    typedef struct packed {
        logic ld_c1;
        logic ld_c2;
    } fetch_t;

    // Font: rows 0..7 top to bottom, then width; bit 0 is the rightmost column
    localparam logic [GLYPH_ENTRY_W-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
        {5'd2, 5'd5, 5'd5, 5'd7, 5'd5, 5'd5, 5'd0, 5'd0, 3'd3},
        {5'd6, 5'd5, 5'd6, 5'd5, 5'd5, 5'd6, 5'd0, 5'd0, 3'd3},
        {5'd3, 5'd4, 5'd4, 5'd4, 5'd4, 5'd3, 5'd0, 5'd0, 3'd3},
        {5'd6, 5'd5, 5'd5, 5'd5, 5'd5, 5'd6, 5'd0, 5'd0, 3'd3},
        {5'd7, 5'd4, 5'd6, 5'd4, 5'd4, 5'd7, 5'd0, 5'd0, 3'd3},
        {5'd7, 5'd4, 5'd6, 5'd4, 5'd4, 5'd4, 5'd0, 5'd0, 3'd3},
        {5'd6, 5'd8, 5'd8, 5'd11, 5'd9, 5'd6, 5'd0, 5'd0, 3'd4},
        {5'd5, 5'd5, 5'd7, 5'd5, 5'd5, 5'd5, 5'd0, 5'd0, 3'd3},
        {5'd7, 5'd2, 5'd2, 5'd2, 5'd2, 5'd7, 5'd0, 5'd0, 3'd3},
        {5'd7, 5'd2, 5'd2, 5'd2, 5'd10, 5'd4, 5'd0, 5'd0, 3'd4},
        {5'd5, 5'd5, 5'd6, 5'd5, 5'd5, 5'd5, 5'd0, 5'd0, 3'd3},
        {5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd7, 5'd0, 5'd0, 3'd3},
        {5'd17, 5'd27, 5'd21, 5'd17, 5'd17, 5'd17, 5'd0, 5'd0, 3'd5},
        {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd0, 5'd0, 3'd5},
        {5'd6, 5'd9, 5'd9, 5'd9, 5'd9, 5'd6, 5'd0, 5'd0, 3'd4},
        {5'd6, 5'd5, 5'd6, 5'd4, 5'd4, 5'd4, 5'd0, 5'd0, 3'd3},
        {5'd12, 5'd18, 5'd18, 5'd18, 5'd22, 5'd14, 5'd1, 5'd0, 3'd5},
        {5'd6, 5'd5, 5'd6, 5'd5, 5'd5, 5'd5, 5'd0, 5'd0, 3'd3},
        {5'd3, 5'd4, 5'd2, 5'd1, 5'd1, 5'd6, 5'd0, 5'd0, 3'd3},
        {5'd7, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd0, 5'd0, 3'd3},
        {5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd7, 5'd0, 5'd0, 3'd3},
        {5'd17, 5'd17, 5'd17, 5'd10, 5'd10, 5'd4, 5'd0, 5'd0, 3'd5},
        {5'd17, 5'd17, 5'd17, 5'd17, 5'd21, 5'd10, 5'd0, 5'd0, 3'd5},
        {5'd5, 5'd5, 5'd2, 5'd5, 5'd5, 5'd5, 5'd0, 5'd0, 3'd3},
        {5'd5, 5'd5, 5'd2, 5'd2, 5'd2, 5'd2, 5'd0, 5'd0, 3'd3},
        {5'd7, 5'd1, 5'd2, 5'd2, 5'd4, 5'd7, 5'd0, 5'd0, 3'd3},
        {5'd0, 5'd6, 5'd1, 5'd7, 5'd9, 5'd7, 5'd0, 5'd0, 3'd4},
        {5'd0, 5'd4, 5'd4, 5'd6, 5'd5, 5'd6, 5'd0, 5'd0, 3'd3},
        {5'd0, 5'd0, 5'd3, 5'd4, 5'd4, 5'd3, 5'd0, 5'd0, 3'd3},
        {5'd0, 5'd1, 5'd1, 5'd3, 5'd5, 5'd3, 5'd0, 5'd0, 3'd3},
        {5'd0, 5'd6, 5'd9, 5'd14, 5'd8, 5'd6, 5'd0, 5'd0, 3'd4},
        {5'd0, 5'd3, 5'd4, 5'd6, 5'd4, 5'd4, 5'd0, 5'd0, 3'd3},
        {5'd0, 5'd0, 5'd6, 5'd9, 5'd9, 5'd7, 5'd1, 5'd6, 3'd4},
        {5'd0, 5'd4, 5'd4, 5'd6, 5'd5, 5'd5, 5'd0, 5'd0, 3'd3},
        {5'd0, 5'd1, 5'd0, 5'd1, 5'd1, 5'd1, 5'd0, 5'd0, 3'd1},
        {5'd0, 5'd1, 5'd0, 5'd1, 5'd1, 5'd1, 5'd5, 5'd2, 3'd3},
        {5'd0, 5'd4, 5'd4, 5'd6, 5'd7, 5'd5, 5'd0, 5'd0, 3'd3},
        {5'd0, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd0, 5'd0, 3'd1},
        {5'd0, 5'd0, 5'd26, 5'd21, 5'd21, 5'd21, 5'd0, 5'd0, 3'd5},
        {5'd0, 5'd0, 5'd6, 5'd5, 5'd5, 5'd5, 5'd0, 5'd0, 3'd3},
        {5'd0, 5'd0, 5'd6, 5'd9, 5'd9, 5'd6, 5'd0, 5'd0, 3'd4},
        {5'd0, 5'd0, 5'd6, 5'd9, 5'd9, 5'd14, 5'd8, 5'd8, 3'd4},
        {5'd0, 5'd0, 5'd6, 5'd9, 5'd9, 5'd7, 5'd1, 5'd1, 3'd4},
        {5'd0, 5'd0, 5'd3, 5'd4, 5'd4, 5'd4, 5'd0, 5'd0, 3'd3},
        {5'd0, 5'd3, 5'd4, 5'd2, 5'd1, 5'd6, 5'd0, 5'd0, 3'd3},
        {5'd0, 5'd2, 5'd7, 5'd2, 5'd2, 5'd3, 5'd0, 5'd0, 3'd3},
        {5'd0, 5'd0, 5'd5, 5'd5, 5'd5, 5'd3, 5'd0, 5'd0, 3'd3},
        {5'd0, 5'd0, 5'd5, 5'd5, 5'd5, 5'd2, 5'd0, 5'd0, 3'd3},
        {5'd0, 5'd0, 5'd17, 5'd17, 5'd21, 5'd10, 5'd0, 5'd0, 3'd5},
        {5'd0, 5'd0, 5'd5, 5'd2, 5'd5, 5'd5, 5'd0, 5'd0, 3'd3},
        {5'd0, 5'd0, 5'd5, 5'd5, 5'd5, 5'd3, 5'd1, 5'd2, 3'd3},
        {5'd0, 5'd0, 5'd3, 5'd1, 5'd2, 5'd3, 5'd0, 5'd0, 3'd2},
        {5'd0, 5'd6, 5'd9, 5'd9, 5'd9, 5'd6, 5'd0, 5'd0, 3'd4},
        {5'd0, 5'd2, 5'd6, 5'd2, 5'd2, 5'd7, 5'd0, 5'd0, 3'd3},
        {5'd0, 5'd6, 5'd1, 5'd2, 5'd4, 5'd7, 5'd0, 5'd0, 3'd3},
        {5'd0, 5'd6, 5'd1, 5'd6, 5'd1, 5'd6, 5'd0, 5'd0, 3'd3},
        {5'd0, 5'd5, 5'd5, 5'd7, 5'd1, 5'd1, 5'd0, 5'd0, 3'd3},
        {5'd0, 5'd7, 5'd4, 5'd2, 5'd1, 5'd6, 5'd0, 5'd0, 3'd3},
        {5'd0, 5'd6, 5'd8, 5'd15, 5'd9, 5'd6, 5'd0, 5'd0, 3'd4},
        {5'd0, 5'd14, 5'd2, 5'd7, 5'd2, 5'd2, 5'd0, 5'd0, 3'd4},
        {5'd0, 5'd6, 5'd9, 5'd6, 5'd9, 5'd6, 5'd0, 5'd0, 3'd4},
        {5'd0, 5'd6, 5'd9, 5'd7, 5'd1, 5'd6, 5'd0, 5'd0, 3'd4}
    };

    // Map a character code to its glyph; codes outside the font are blank
    function automatic glyph_t glyph_lookup(input logic [CODE_W-1:0] code);
        logic [GLYPH_IDX_W-1:0]   g;
        logic                     hit;
        logic [GLYPH_ENTRY_W-1:0] ent;
        glyph_t                   res;
        g   = '0;
        hit = 1'b1;
        if (code >= CODE_UPPER_A && code <= CODE_UPPER_Z) begin
            g = GLYPH_IDX_W'(code - CODE_UPPER_A);
        end
        else if (code >= CODE_LOWER_A && code <= CODE_LOWER_Z) begin
            g = GLYPH_IDX_W'(code - CODE_LOWER_A) + GLYPH_IDX_W'(LOWER_BASE);
        end
        else if (code >= CODE_DIGIT_0 && code <= CODE_DIGIT_9) begin
            g = GLYPH_IDX_W'(code - CODE_DIGIT_0) + GLYPH_IDX_W'(DIGIT_BASE);
        end
        else begin
            hit = 1'b0;
        end
        ent       = GLYPH_ROM[g];
        res.width = hit ? ent[GLYPH_WIDTH_W-1:0] : BLANK_WIDTH;
        for (int r = 0; r < MATRIX_ROWS; r++) begin
            res.rows[r] = hit ? ent[GLYPH_ENTRY_W-1-GLYPH_ROW_W*r -: GLYPH_ROW_W] : '0;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/led_matrix_text_scroller_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// led_matrix_text_scroller_core
// Scrolls stored text across an 8x8 LED matrix with a proportional font.
// ----------------------------------------------------------------------------
// Results: a tick's frame is on m_tdata in the cycle after acceptance unless
//   earlier frames still wait; writes and restarts give no result.
// Throughput: one request per cycle; s_tready drops only while both result
//   queue entries are full, which stalls every request kind.
// Reset: control state and frame rows clear, gap registers load 3 and 8;
//   the text store stays undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
module led_matrix_text_scroller_core
    import lmts_pkg::*;
#(
    parameter int TEXT_DEPTH = 64
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,    // char_index[5:0], char_code[13:6]
    input  wire logic [OP_W-1:0]        s_tuser,    // operation[1:0]
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [M_TDATA_W-1:0]   m_tdata,    // row_0[7:0] .. row_7[63:56]
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [GAP_W-1:0]       cfg_data
);

    localparam int POS_W = $clog2(TEXT_DEPTH);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(TEXT_DEPTH - 1);
    localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_TWO  = POS_W'(2 % TEXT_DEPTH);

    function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
        return (p == POS_LAST) ? '0 : p + 1'b1;
    endfunction

    // Configuration
    logic [GAP_W-1:0]   space_gap_reg;
    logic [GAP_W-1:0]   wrap_gap_reg;

    // Scroll state and lookahead cache of store[pos], store[pos+1], store[pos+2]
    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               gap_reg,   gap_next;
    frame_t             frame_reg, frame_next;
    logic [CODE_W-1:0]  c0_reg,    c0_next;
    logic [CODE_W-1:0]  c1_reg,    c1_next;
    logic [CODE_W-1:0]  c2_reg,    c2_next;
    logic [CODE_W-1:0]  first_code_reg, first_code_next;
    fetch_t             fetch_reg, fetch_next;

    // Request decode
    logic               in_acc;
    op_t                op;
    logic [INDEX_W-1:0] wr_index;
    logic [CODE_W-1:0]  wr_code;
    logic               wr_ok;
    logic [POS_W-1:0]   wr_pos;

    // Datapath
    logic [POS_W-1:0]   p1, p2, p3, p4;
    logic [CODE_W-1:0]  c1_cur, c2_cur;
    logic [CODE_W-1:0]  rd_a, rd_b;
    logic [POS_W-1:0]   raddr_a, raddr_b;
    logic               mem_we;
    glyph_t             g0;
    logic               step;
    logic [2:0]         col_sel;
    logic [MATRIX_ROWS-1:0] col_bits;
    logic [COUNT_W-1:0] tick_count;
    logic               tick_gap;
    logic               push;
    logic               push_ready;

    assign in_acc    = s_tvalid && s_tready;
    assign s_tready  = push_ready;
    assign cfg_ready = 1'b1;
    assign op        = op_t'(s_tuser);
    assign wr_index  = s_tdata[INDEX_W-1:0];
    assign wr_code   = s_tdata[INDEX_W +: CODE_W];
    assign wr_ok     = (int'(wr_index) < TEXT_DEPTH);
    assign wr_pos    = POS_W'(wr_index);

    assign p1 = pos_inc(pos_reg);
    assign p2 = pos_inc(p1);
    assign p3 = pos_inc(p2);
    assign p4 = pos_inc(p3);

    // Take fetched codes in the cycle after a fetch
    assign c1_cur = fetch_reg.ld_c1 ? rd_a : c1_reg;
    assign c2_cur = fetch_reg.ld_c2 ? rd_b : c2_reg;

    // Glyph of the current character and the column to shift in
    assign g0      = glyph_lookup(c0_reg);
    assign step    = !gap_reg && ((COUNT_W'(g0.width) <= count_reg)
                     || (c0_reg == CODE_SPACE) || (c0_reg == CODE_NUL));
    assign col_sel = 3'(g0.width - 3'd1 - count_reg[2:0]);

    always_comb
    begin
        for (int r = 0; r < MATRIX_ROWS; r++)
        begin
            col_bits[r] = |({3'b000, g0.rows[r]} & (8'd1 << col_sel));
        end
    end

    lmts_text_mem #(
        .DEPTH  (TEXT_DEPTH),
        .ADDR_W (POS_W)
    ) u_text_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (wr_pos),
        .wdata   (wr_code),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // Decode a request and update scroll state
    always_comb
    begin
        pos_next        = pos_reg;
        count_next      = count_reg;
        gap_next        = gap_reg;
        frame_next      = frame_reg;
        c0_next         = c0_reg;
        c1_next         = c1_cur;
        c2_next         = c2_cur;
        first_code_next = first_code_reg;
        fetch_next      = '0;
        raddr_a         = p3;
        raddr_b         = p4;
        mem_we          = 1'b0;
        push            = 1'b0;
        tick_count      = count_reg;
        tick_gap        = gap_reg;
        if (in_acc)
        begin
            unique case (op)
                OP_WRITE:
                begin
                    // Store and forward into the lookahead
                    if (wr_ok)
                    begin
                        mem_we = 1'b1;
                        if (wr_pos == pos_reg)
                        begin
                            c0_next = wr_code;
                        end
                        if (wr_pos == p1)
                        begin
                            c1_next = wr_code;
                        end
                        if (wr_pos == p2)
                        begin
                            c2_next = wr_code;
                        end
                        if (wr_pos == '0)
                        begin
                            first_code_next = wr_code;
                        end
                    end
                end
                OP_RESTART:
                begin
                    frame_next = '0;
                    pos_next   = '0;
                    count_next = '0;
                    gap_next   = 1'b0;
                    c0_next    = first_code_reg;
                    fetch_next = '{ld_c1: 1'b1, ld_c2: 1'b1};
                    raddr_a    = POS_ONE;
                    raddr_b    = POS_TWO;
                end
                OP_TICK:
                begin
                    push = 1'b1;
                    // Advance to the next character and pick the gap
                    if (step)
                    begin
                        tick_gap = 1'b1;
                        if (c1_cur == CODE_SPACE && c2_cur != CODE_NUL)
                        begin
                            tick_count = space_gap_reg;
                            pos_next   = p2;
                            c0_next    = c2_cur;
                            fetch_next = '{ld_c1: 1'b1, ld_c2: 1'b1};
                            raddr_a    = p3;
                            raddr_b    = p4;
                        end
                        else if (c1_cur == CODE_SPACE || c1_cur == CODE_NUL)
                        begin
                            tick_count = (c1_cur == CODE_SPACE) ? space_gap_reg : wrap_gap_reg;
                            pos_next   = '0;
                            c0_next    = first_code_reg;
                            fetch_next = '{ld_c1: 1'b1, ld_c2: 1'b1};
                            raddr_a    = POS_ONE;
                            raddr_b    = POS_TWO;
                        end
                        else
                        begin
                            tick_count = COUNT_W'(1);
                            pos_next   = p1;
                            c0_next    = c1_cur;
                            c1_next    = c2_cur;
                            fetch_next = '{ld_c1: 1'b0, ld_c2: 1'b1};
                            raddr_b    = p3;
                        end
                    end
                    // Shift in a blank or a glyph column
                    if (tick_gap)
                    begin
                        for (int r = 0; r < MATRIX_ROWS; r++)
                        begin
                            frame_next[r] = {frame_reg[r][ROW_W-2:0], 1'b0};
                        end
                        tick_count = tick_count - COUNT_W'(1);
                        tick_gap   = (tick_count != '0);
                    end
                    else
                    begin
                        for (int r = 0; r < MATRIX_ROWS; r++)
                        begin
                            frame_next[r] = {frame_reg[r][ROW_W-2:0], col_bits[r]};
                        end
                        tick_count = tick_count + COUNT_W'(1);
                    end
                    count_next = tick_count;
                    gap_next   = tick_gap;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            count_reg <= '0;
            gap_reg   <= 1'b0;
            frame_reg <= '0;
            fetch_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            count_reg <= count_next;
            gap_reg   <= gap_next;
            frame_reg <= frame_next;
            fetch_reg <= fetch_next;
        end
    end

    // Lookahead payload
    always_ff @(posedge clk)
    begin
        c0_reg         <= c0_next;
        c1_reg         <= c1_next;
        c2_reg         <= c2_next;
        first_code_reg <= first_code_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            space_gap_reg <= SPACE_GAP_RESET;
            wrap_gap_reg  <= WRAP_GAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_SPACE_GAP)
            begin
                space_gap_reg <= cfg_data;
            end
            else if (cfg_index == CFG_WRAP_GAP)
            begin
                wrap_gap_reg <= cfg_data;
            end
        end
    end

    lmts_out_q u_out_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (frame_next),
        .push_ready (push_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // A gap always has columns left to shift in
    a_gap_count: assert property (@(posedge clk) disable iff (!rst_n)
        gap_reg |-> (count_reg != '0))
        else $error("gap active with zero count");

    // A c1 lookahead fetch never comes without a c2 fetch
    a_fetch_pair: assert property (@(posedge clk) disable iff (!rst_n)
        fetch_reg.ld_c1 |-> fetch_reg.ld_c2)
        else $error("c1 fetch without c2 fetch");

    // Fetches follow an accepted request
    a_fetch_cause: assert property (@(posedge clk) disable iff (!rst_n)
        fetch_reg.ld_c2 |-> $past(s_tvalid && s_tready))
        else $error("fetch pending without request");

    // A tick request always yields a result
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == OP_TICK) |=> m_tvalid)
        else $error("tick gave no result");

endmodule
`default_nettype wire

// ===== rtl/lmts_text_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmts_text_mem
// Text store: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module lmts_text_mem
    import lmts_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [CODE_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr_a,
    input  wire logic [ADDR_W-1:0] raddr_b,
    output logic      [CODE_W-1:0] rdata_a,
    output logic      [CODE_W-1:0] rdata_b
);

    logic [CODE_W-1:0] mem [DEPTH];
    logic [CODE_W-1:0] rdata_a_reg;
    logic [CODE_W-1:0] rdata_b_reg;

    // Store a written character
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read both ports every cycle
    always_ff @(posedge clk)
    begin
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule
`default_nettype wire

// ===== rtl/lmts_out_q.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmts_out_q
// Two-entry result queue between the scroller and the output stream.
// ----------------------------------------------------------------------------
module lmts_out_q
    import lmts_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic [M_TDATA_W-1:0] push_data,
    output logic                      push_ready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata
);

    logic [M_TDATA_W-1:0] ent_reg [2];
    logic                 wr_ptr_reg;
    logic                 wr_ptr_next;
    logic                 rd_ptr_reg;
    logic                 rd_ptr_next;
    logic [1:0]           count_reg;
    logic [1:0]           count_next;
    logic                 pop;

    assign pop        = m_tvalid && m_tready;
    assign push_ready = (count_reg != 2'd2);
    assign m_tvalid   = (count_reg != 2'd0);
    assign m_tdata    = ent_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire
